@@ design/mpm2_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// 2x2 matrix power modulo prime: shared types and constants
// Transaction payloads, the pipeline tag that travels with each product, and
// the prime modulus used by every stage.
// ----------------------------------------------------------------------------
package mpm2_pkg;

   localparam int EntryWidth = 30;
   localparam int ExpWidth   = 63;
   localparam int TagWidth   = 4;

   // The prime 1000000007 fits in the entry width.
   localparam logic [EntryWidth-1:0] Prime = 30'd1000000007;

   typedef struct packed {
      logic [EntryWidth-1:0] entry_r0c0;
      logic [EntryWidth-1:0] entry_r0c1;
      logic [EntryWidth-1:0] entry_r1c0;
      logic [EntryWidth-1:0] entry_r1c1;
      logic [ExpWidth-1:0]   exponent;
   } mpm2_req_type;

   typedef struct packed {
      logic [EntryWidth-1:0] power_r0c0;
      logic [EntryWidth-1:0] power_r0c1;
      logic [EntryWidth-1:0] power_r1c0;
      logic [EntryWidth-1:0] power_r1c1;
   } mpm2_rsp_type;

   // Control that moves alongside one product through the multiplier.
   typedef struct packed {
      logic                valid;
      logic [TagWidth-1:0] tag;
   } mpm2_op_type;

endpackage : mpm2_pkg
`default_nettype wire

@@ design/mpm2_modmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined modular multiplier
// Five-stage Barrett multiplier: takes one pair of residues every cycle and
// returns their product modulo the prime, with its tag.
// ----------------------------------------------------------------------------
module mpm2_modmul
   import mpm2_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mpm2_op_type           in_op,
   input  wire logic [EntryWidth-1:0] op_a,
   input  wire logic [EntryWidth-1:0] op_b,
   output mpm2_op_type                out_op,
   output logic [EntryWidth-1:0]      result
);

   // Barrett reciprocal floor(2^60 / P), and the correction thresholds.
   localparam logic [30:0] Mu       = 31'((64'd1 << 60) / 64'(Prime));
   localparam logic [31:0] OnePrime = 32'(Prime);
   localparam logic [31:0] TwoPrime = 32'(64'(Prime) * 64'd2);

   mpm2_op_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;

   logic [59:0] prod_in, prod_ff;
   logic [61:0] q2_in, q2_ff;
   logic [31:0] xlo2_ff, xlo3_ff;
   logic [31:0] qp_in, qp_ff;
   logic [31:0] rem_in, rem_ff;
   logic [EntryWidth-1:0] result_in, result_ff;

   // Full product, then the quotient estimate, then the estimate times P.
   assign prod_in = op_a * op_b;
   assign q2_in   = prod_ff[59:29] * Mu;
   assign qp_in   = 32'(q2_ff[61:31]) * OnePrime;

   // The estimate is at most two short, so the remainder lies below 3P.
   assign rem_in = xlo3_ff - qp_ff;

   always_comb begin
      if (rem_ff >= TwoPrime) begin
         result_in = EntryWidth'(rem_ff - TwoPrime);
      end else if (rem_ff >= OnePrime) begin
         result_in = EntryWidth'(rem_ff - OnePrime);
      end else begin
         result_in = EntryWidth'(rem_ff);
      end
   end

   // Control pipeline: valid bits are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else begin
         ctl1_ff <= in_op;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
      end
   end

   // Data pipeline.
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      q2_ff     <= q2_in;
      xlo2_ff   <= prod_ff[31:0];
      xlo3_ff   <= xlo2_ff;
      qp_ff     <= qp_in;
      rem_ff    <= rem_in;
      result_ff <= result_in;
   end

   assign out_op = ctl5_ff;
   assign result = result_ff;

endmodule : mpm2_modmul
`default_nettype wire

@@ design/matrix_power_mod_prime_2x2_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// 2x2 matrix power modulo 1000000007
// Raises a 2x2 matrix of residues to a binary exponent by repeated squaring,
// with every product formed on one shared pipelined modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high while busy is low. req_data
//   carries the four entries and the exponent; entries at or above the prime
//   are reduced first, and only the low EXPONENT_BITS exponent bits count.
//   busy stays high until the result has been presented.
//   The result appears on rsp_data for exactly one cycle, marked by
//   rsp_valid; the receiver cannot stall it and must take it then.
// Sequencing:
//   For each exponent bit the sequencer issues products to the multiplier:
//   8 for the squaring, 8 more when the bit is set, and no squaring after
//   the highest set bit. It then waits for the last product to leave the
//   five-stage multiplier and commits the new matrices in one state. The
//   next transaction can be taken in the cycle after the strobe, so one
//   transaction is in flight at a time.
// Reset:
//   A synchronous reset returns the sequencer to idle and drops any
//   transaction in progress; no result is produced for it.
// ----------------------------------------------------------------------------
module matrix_power_mod_prime_2x2_core
   import mpm2_pkg::*;
#(
   parameter int EXPONENT_BITS = 63
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire mpm2_req_type req_data,
   output logic              rsp_valid,
   output mpm2_rsp_type      rsp_data
);

   // Exponent bits actually used, and the mask that keeps them.
   localparam int NumBits = (EXPONENT_BITS < ExpWidth) ? EXPONENT_BITS : ExpWidth;
   localparam logic [ExpWidth-1:0] ExpMask = {ExpWidth{1'b1}} >> (ExpWidth - NumBits);

   // Product indices: the lower half multiplies the result by the base,
   // the upper half squares the base.
   localparam logic [TagWidth-1:0] IdxAccFirst  = 4'd0;
   localparam logic [TagWidth-1:0] IdxAccLast   = 4'd7;
   localparam logic [TagWidth-1:0] IdxSqrFirst  = 4'd8;
   localparam logic [TagWidth-1:0] IdxSqrLast   = 4'd15;

   localparam logic [EntryWidth-1:0] One  = 30'd1;
   localparam logic [EntryWidth-1:0] Zero = 30'd0;

   // Sequencer states.
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StIssue  = 3'd1;
   localparam logic [2:0] StDrain  = 3'd2;
   localparam logic [2:0] StCommit = 3'd3;
   localparam logic [2:0] StDone   = 3'd4;

   typedef struct packed {
      logic [EntryWidth-1:0] e00;
      logic [EntryWidth-1:0] e01;
      logic [EntryWidth-1:0] e10;
      logic [EntryWidth-1:0] e11;
   } mpm2_mat_type;

   logic [2:0]          state_ff, state_in;
   logic [TagWidth-1:0] idx_ff, idx_in;
   logic [ExpWidth-1:0] exp_ff, exp_in;
   mpm2_mat_type        acc_ff, acc_in;
   mpm2_mat_type        base_ff, base_in;
   mpm2_mat_type        next_acc_ff, next_acc_in;
   mpm2_mat_type        next_base_ff, next_base_in;
   logic [EntryWidth-1:0] partial_ff, partial_in;

   logic                  accept;
   logic [ExpWidth-1:0]   exp_masked;
   logic                  more_bits;
   logic [TagWidth-1:0]   last_idx;
   mpm2_mat_type          mat_x;
   mpm2_op_type           mm_in_op;
   mpm2_op_type           mm_out_op;
   logic [EntryWidth-1:0] mm_a, mm_b, mm_result;
   logic [EntryWidth:0]   sum_raw;
   logic [EntryWidth-1:0] sum_red;

   // Select one entry of a matrix by row and column.
   function automatic logic [EntryWidth-1:0] pick(input mpm2_mat_type m,
                                                  input logic row,
                                                  input logic col);
      logic [EntryWidth-1:0] v;
      case ({row, col})
         2'b00:   v = m.e00;
         2'b01:   v = m.e01;
         2'b10:   v = m.e10;
         default: v = m.e11;
      endcase
      return v;
   endfunction

   // Bring an input entry below the prime; it is below twice the prime.
   function automatic logic [EntryWidth-1:0] reduce_once(input logic [EntryWidth-1:0] v);
      return (v >= Prime) ? (v - Prime) : v;
   endfunction

   // Write one entry of a matrix by row and column.
   function automatic mpm2_mat_type place(input mpm2_mat_type m,
                                          input logic [1:0] pos,
                                          input logic [EntryWidth-1:0] v);
      mpm2_mat_type r;
      r = m;
      case (pos)
         2'b00:   r.e00 = v;
         2'b01:   r.e01 = v;
         2'b10:   r.e10 = v;
         default: r.e11 = v;
      endcase
      return r;
   endfunction

   assign accept     = start && !busy;
   assign exp_masked = req_data.exponent & ExpMask;
   assign more_bits  = |exp_ff[ExpWidth-1:1];
   assign last_idx   = more_bits ? IdxSqrLast : IdxAccLast;

   // Operand selection: product idx forms X[i][k] * Y[k][j] with
   // i = idx[2], j = idx[1], k = idx[0].
   assign mat_x          = idx_ff[3] ? base_ff : acc_ff;
   assign mm_a           = pick(mat_x, idx_ff[2], idx_ff[0]);
   assign mm_b           = pick(base_ff, idx_ff[0], idx_ff[1]);
   assign mm_in_op.valid = (state_ff == StIssue);
   assign mm_in_op.tag   = idx_ff;

   mpm2_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .in_op  (mm_in_op),
      .op_a   (mm_a),
      .op_b   (mm_b),
      .out_op (mm_out_op),
      .result (mm_result)
   );

   // Pairwise sum of the two products that make one entry.
   assign sum_raw = {1'b0, partial_ff} + {1'b0, mm_result};
   assign sum_red = (sum_raw >= {1'b0, Prime}) ? EntryWidth'(sum_raw - {1'b0, Prime})
                                               : EntryWidth'(sum_raw);

   // Collect returning products into the shadow matrices.
   always_comb begin
      partial_in   = partial_ff;
      next_acc_in  = next_acc_ff;
      next_base_in = next_base_ff;
      if (mm_out_op.valid) begin
         if (!mm_out_op.tag[0]) begin
            partial_in = mm_result;
         end else if (mm_out_op.tag[3]) begin
            next_base_in = place(next_base_ff, mm_out_op.tag[2:1], sum_red);
         end else begin
            next_acc_in = place(next_acc_ff, mm_out_op.tag[2:1], sum_red);
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      exp_in   = exp_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               acc_in.e00 = One;
               acc_in.e01 = Zero;
               acc_in.e10 = Zero;
               acc_in.e11 = One;
               base_in.e00 = reduce_once(req_data.entry_r0c0);
               base_in.e01 = reduce_once(req_data.entry_r0c1);
               base_in.e10 = reduce_once(req_data.entry_r1c0);
               base_in.e11 = reduce_once(req_data.entry_r1c1);
               exp_in = exp_masked;
               idx_in = exp_masked[0] ? IdxAccFirst : IdxSqrFirst;
               state_in = (exp_masked == '0) ? StDone : StIssue;
            end
         end
         StIssue: begin
            if (idx_ff == last_idx) begin
               state_in = StDrain;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         StDrain: begin
            if (mm_out_op.valid && (mm_out_op.tag == last_idx)) begin
               state_in = StCommit;
            end
         end
         StCommit: begin
            if (exp_ff[0]) begin
               acc_in = next_acc_ff;
            end
            if (more_bits) begin
               base_in  = next_base_ff;
               idx_in   = exp_ff[1] ? IdxAccFirst : IdxSqrFirst;
               state_in = StIssue;
            end else begin
               state_in = StDone;
            end
            exp_in = exp_ff >> 1;
         end
         StDone: begin
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      next_acc_ff  <= next_acc_in;
      next_base_ff <= next_base_in;
      partial_ff   <= partial_in;
   end

   // Result ports.
   assign busy                = (state_ff != StIdle);
   assign rsp_valid           = (state_ff == StDone);
   assign rsp_data.power_r0c0 = acc_ff.e00;
   assign rsp_data.power_r0c1 = acc_ff.e01;
   assign rsp_data.power_r1c0 = acc_ff.e10;
   assign rsp_data.power_r1c1 = acc_ff.e11;

   // A result strobe lasts one cycle and the block is then free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe held or block not released");

   // Every delivered entry is a proper residue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.power_r0c0 < Prime) && (rsp_data.power_r0c1 < Prime) &&
                     (rsp_data.power_r1c0 < Prime) && (rsp_data.power_r1c1 < Prime)))
      else $error("result entry not reduced");

   // Products only return while the sequencer is collecting them.
   assert property (@(posedge clock) disable iff (reset)
      mm_out_op.valid |-> ((state_ff == StIssue) || (state_ff == StDrain)))
      else $error("multiplier result outside issue or drain");

   // An accepted transaction makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule : matrix_power_mod_prime_2x2_core
`default_nettype wire

@@ test/mpm2_power_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 2x2 matrix power modulo prime: transaction checker
// Watches the request and result channels of the core. For every accepted
// request it works out the matrix power independently and queues it. Every
// result strobe is then compared, entry by entry, with the oldest queued power.
// ----------------------------------------------------------------------------
module mpm2_power_checker
   import mpm2_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire mpm2_req_type req_data,
   input  wire logic         rsp_valid,
   input  wire mpm2_rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);

   localparam logic [63:0] Modulus = 64'(Prime);

   // Four residues of a 2x2 matrix, row-major: index 2*row + column.
   typedef logic [3:0][63:0] residue_quad;

   mpm2_rsp_type expected_powers[$];
   int           mismatches = 0;
   int           outstanding = 0;
   int           results_seen = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;
   assign checked_count = results_seen;

   function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b);
      return (a * b) % Modulus;
   endfunction

   function automatic residue_quad mat_product(input residue_quad p, input residue_quad q);
      residue_quad r;
      logic [63:0] sum;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            sum = mul_mod(p[2*i], q[j]) + mul_mod(p[2*i+1], q[2+j]);
            r[2*i+j] = (sum >= Modulus) ? sum - Modulus : sum;
         end
      end
      return r;
   endfunction

   // Right-to-left square and multiply over every exponent bit.
   function automatic mpm2_rsp_type matrix_power(input mpm2_req_type item);
      residue_quad  base;
      residue_quad  acc;
      mpm2_rsp_type res;
      base[0] = 64'(item.entry_r0c0) % Modulus;
      base[1] = 64'(item.entry_r0c1) % Modulus;
      base[2] = 64'(item.entry_r1c0) % Modulus;
      base[3] = 64'(item.entry_r1c1) % Modulus;
      acc     = {64'd1, 64'd0, 64'd0, 64'd1};
      for (int k = 0; k < ExpWidth; k++) begin
         if (item.exponent[k]) begin
            acc = mat_product(acc, base);
         end
         base = mat_product(base, base);
      end
      res.power_r0c0 = acc[0][EntryWidth-1:0];
      res.power_r0c1 = acc[1][EntryWidth-1:0];
      res.power_r1c0 = acc[2][EntryWidth-1:0];
      res.power_r1c1 = acc[3][EntryWidth-1:0];
      return res;
   endfunction

   // Results are checked before a new request is queued, so a strobe can
   // never be matched against a request taken at the same edge.
   always @(posedge clock) begin
      mpm2_rsp_type          want;
      logic [EntryWidth-1:0] want_e [4];
      logic [EntryWidth-1:0] got_e  [4];
      string                 names  [4];
      names = '{"power_r0c0", "power_r0c1", "power_r1c0", "power_r1c1"};
      if (!reset) begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
               mismatches++;
               $display("%0t: result with no request outstanding: %h", $time, rsp_data);
            end else begin
               want   = expected_powers.pop_front();
               want_e = '{want.power_r0c0, want.power_r0c1,
                          want.power_r1c0, want.power_r1c1};
               got_e  = '{rsp_data.power_r0c0, rsp_data.power_r0c1,
                          rsp_data.power_r1c0, rsp_data.power_r1c1};
               for (int f = 0; f < 4; f++) begin
                  if (got_e[f] !== want_e[f]) begin
                     mismatches++;
                     $display("%0t: %s mismatch: expected %0d, actual %0d",
                              $time, names[f], want_e[f], got_e[f]);
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_powers.push_back(matrix_power(req_data));
         end
         outstanding = expected_powers.size();
      end
   end

endmodule : mpm2_power_checker

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 2x2 matrix power modulo prime: testbench top
// Drives the core with a short directed set of matrices and exponents, then
// with several hundred random transactions, idling the request side in
// random bursts. The checker beside the core predicts and compares; this top
// only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import mpm2_pkg::*;

   localparam int RandomItems = 580;
   localparam int QuietTail   = 60;
   localparam int CycleLimit  = 2_600_000;

   localparam logic [EntryWidth-1:0] EntryMax    = '1;
   localparam logic [EntryWidth-1:0] PrimeLess1  = Prime - 30'd1;
   localparam logic [ExpWidth-1:0]   ExponentMax = '1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   mpm2_req_type req_data = '0;
   logic         busy;
   logic         rsp_valid;
   mpm2_rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int cycle_count = 0;
   int sent_count = 0;
   int zero_exp_count = 0;
   int full_exp_count = 0;
   int unreduced_count = 0;

   always #6 clock = ~clock;

   matrix_power_mod_prime_2x2_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   mpm2_power_checker power_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Watchdog against a hung core.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic mpm2_req_type make_item(input logic [EntryWidth-1:0] e00,
                                               input logic [EntryWidth-1:0] e01,
                                               input logic [EntryWidth-1:0] e10,
                                               input logic [EntryWidth-1:0] e11,
                                               input logic [ExpWidth-1:0]   power);
      mpm2_req_type item;
      item.entry_r0c0 = e00;
      item.entry_r0c1 = e01;
      item.entry_r1c0 = e10;
      item.entry_r1c1 = e11;
      item.exponent   = power;
      return item;
   endfunction

   // Mostly proper residues, with a share near the prime, above it and tiny.
   function automatic logic [EntryWidth-1:0] random_entry();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return EntryWidth'($urandom_range(0, int'(PrimeLess1)));
      else if (pick < 72) return Prime - 30'd2 + EntryWidth'($urandom_range(0, 4));
      else if (pick < 88) return EntryWidth'($urandom);
      else return EntryWidth'($urandom_range(0, 3));
   endfunction

   // Short exponents keep most transactions quick; a tenth use the full width.
   function automatic logic [ExpWidth-1:0] random_exponent();
      int              pick;
      int              span;
      logic [63:0]     raw;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      if (pick >= 90) return raw[ExpWidth-1:0];
      span = (pick < 70) ? $urandom_range(1, 16) : $urandom_range(17, 40);
      raw  = raw & ((64'd1 << span) - 64'd1);
      raw[span-1] = 1'b1;
      return raw[ExpWidth-1:0];
   endfunction

   // Present one transaction and hold it until the core takes it.
   task automatic send_matrix(input mpm2_req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      sent_count++;
      if (item.exponent == '0) zero_exp_count++;
      if (item.exponent[ExpWidth-1]) full_exp_count++;
      if (item.entry_r0c0 >= Prime || item.entry_r0c1 >= Prime ||
          item.entry_r1c0 >= Prime || item.entry_r1c1 >= Prime) begin
         unreduced_count++;
      end
   endtask

   // Stop requesting and wait for every outstanding result.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      mpm2_req_type directed[$];
      mpm2_req_type item;
      logic         idle_mode;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero exponent, unreduced entries, extreme residues and
      // exponents, the zero and identity matrices and a Fibonacci matrix.
      directed.push_back(make_item(30'd5, 30'd7, 30'd11, 30'd13, '0));
      directed.push_back(make_item(EntryMax, EntryMax, EntryMax, EntryMax, '0));
      directed.push_back(make_item(PrimeLess1, PrimeLess1, PrimeLess1, PrimeLess1, 63'd1));
      directed.push_back(make_item(Prime, Prime, Prime, Prime, 63'd1));
      directed.push_back(make_item(EntryMax, Prime + 30'd1, PrimeLess1, 30'd0, 63'd3));
      directed.push_back(make_item(30'd0, 30'd0, 30'd0, 30'd0, '0));
      directed.push_back(make_item(30'd0, 30'd0, 30'd0, 30'd0, 63'd7));
      directed.push_back(make_item(30'd1, 30'd0, 30'd0, 30'd1, ExponentMax));
      directed.push_back(make_item(30'd1, 30'd1, 30'd1, 30'd0, 63'd10));
      directed.push_back(make_item(30'd1, 30'd1, 30'd1, 30'd0, ExponentMax));
      directed.push_back(make_item(PrimeLess1, PrimeLess1, PrimeLess1, PrimeLess1,
                                   ExponentMax));
      directed.push_back(make_item(30'd2, 30'd0, 30'd0, 30'd3, 63'd1 << 62));
      directed.push_back(make_item(30'd3, 30'd5, 30'd7, 30'd9, 63'h5555_5555_5555_5555));
      directed.push_back(make_item(30'd9, 30'd7, 30'd5, 30'd3, 63'h2AAA_AAAA_AAAA_AAAA));
      directed.push_back(make_item(PrimeLess1, 30'd1, 30'd0, PrimeLess1, 63'd2));
      directed.push_back(make_item(EntryMax, EntryMax, EntryMax, EntryMax, ExponentMax));
      directed.push_back(make_item(30'd123456789, 30'd987654321, 30'd555555555, 30'd1,
                                   63'd1000000006));
      foreach (directed[d]) begin
         send_matrix(directed[d]);
      end

      // Let the core run dry once before the random traffic.
      drain_results();

      // Random: idling toggles in stretches and stops for the final items.
      idle_mode = 1'b1;
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 50 == 0) idle_mode = $urandom_range(0, 2) != 0;
         if (n == RandomItems / 2) drain_results();
         item = make_item(random_entry(), random_entry(), random_entry(), random_entry(),
                          random_exponent());
         send_matrix(item);
         if (idle_mode && n < RandomItems - QuietTail && $urandom_range(0, 99) < 35) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end

      drain_results();
      repeat (20) @(posedge clock);

      $display("Ran %0d matrix powers (%0d with zero exponent, %0d with full-width exponent)",
               sent_count, zero_exp_count, full_exp_count);
      $display("%0d had entries at or above the prime; %0d results were compared",
               unreduced_count, checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule : testbench
